### sv/bmrsc_pkg.sv
package bmrsc_pkg;

  localparam int STORE_BYTES_DEF = 4096;

  // absolute bit address: byte_base * 8 + first_bit (+ bit_count - 1) fits in 17 bits
  localparam int BIT_W  = 17;
  localparam int BYTE_W = BIT_W - 3;

  localparam logic [1:0] FUNC_SET  = 2'd0;
  localparam logic [1:0] FUNC_CLR  = 2'd1;
  localparam logic [1:0] FUNC_TEST = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_TEST,
    ST_DONE
  } state_t;

endpackage

### sv/bmrsc_req_if.sv
interface bmrsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] byte_base;
  logic [14:0] first_bit;
  logic [15:0] bit_count;

  modport source (output valid, func, byte_base, first_bit, bit_count, input ready);
  modport sink   (input valid, func, byte_base, first_bit, bit_count, output ready);
endinterface

### sv/bmrsc_rsp_if.sv
interface bmrsc_rsp_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic out_of_range;

  modport source (output valid, bit_value, out_of_range, input ready);
  modport sink   (input valid, bit_value, out_of_range, output ready);
endinterface

### sv/bitmap_range_set_clear_core.sv
// Sequence: set/clear stays in RUN for each byte spanned by the run, then passes DRAIN and DONE;
// test passes TEST and DONE; zero-length runs, unused func and out-of-range requests go to DONE.
// Throughput: one transaction at a time, the next accepted only after the result has issued;
// the run walks the store RAM one byte per cycle, reading byte b while writing back b-1.
// Reset: synchronous; afterwards the store is zeroed one byte per cycle, during which
// req.ready stays low.
module bitmap_range_set_clear_core #(
  parameter int STORE_BYTES = bmrsc_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  bmrsc_req_if.sink           req,
  bmrsc_rsp_if.source         rsp
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [bmrsc_pkg::BIT_W-1:0] STORE_LIM = bmrsc_pkg::BIT_W'(STORE_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

  bmrsc_pkg::state_t state, state_next;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] cur;
  logic [AW-1:0] first_byte;
  logic [AW-1:0] last_byte;
  logic [2:0]    start_lo;
  logic [2:0]    end_lo;
  logic          set_op;

  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic          wr_first;
  logic          wr_last;

  logic res_bit;
  logic res_oor;
  logic out_valid;
  logic out_bit;
  logic out_oor;

  logic [bmrsc_pkg::BIT_W-1:0]  start_bit;
  logic [bmrsc_pkg::BIT_W-1:0]  end_bit;
  logic [bmrsc_pkg::BYTE_W-1:0] start_byte_in;
  logic [bmrsc_pkg::BYTE_W-1:0] end_byte_in;
  logic is_run;
  logic is_test;
  logic run_zero;
  logic run_oor;
  logic test_oor;
  logic in_fire;
  logic out_free;
  logic [7:0] mask;

  assign start_bit = bmrsc_pkg::BIT_W'({req.byte_base, 3'b000})
                   + bmrsc_pkg::BIT_W'(req.first_bit);
  assign end_bit   = start_bit + bmrsc_pkg::BIT_W'(req.bit_count) - 1'b1;
  assign start_byte_in = start_bit[bmrsc_pkg::BIT_W-1:3];
  assign end_byte_in   = end_bit[bmrsc_pkg::BIT_W-1:3];

  assign is_run   = (req.func == bmrsc_pkg::FUNC_SET) || (req.func == bmrsc_pkg::FUNC_CLR);
  assign is_test  = (req.func == bmrsc_pkg::FUNC_TEST);
  assign run_zero = (req.bit_count == '0);
  assign run_oor  = bmrsc_pkg::BIT_W'(end_byte_in) >= STORE_LIM;
  assign test_oor = bmrsc_pkg::BIT_W'(start_byte_in) >= STORE_LIM;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  assign req.ready        = (state == bmrsc_pkg::ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.bit_value    = out_bit;
  assign rsp.out_of_range = out_oor;

  always_comb begin
    mask = 8'hFF;
    if (wr_first) begin
      mask = mask & (8'hFF << start_lo);
    end
    if (wr_last) begin
      mask = mask & (8'hFF >> (3'd7 - end_lo));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bmrsc_pkg::ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = bmrsc_pkg::ST_IDLE;
        end
      end
      bmrsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_run && !run_zero && !run_oor) begin
            state_next = bmrsc_pkg::ST_RUN;
          end else if (is_test && !test_oor) begin
            state_next = bmrsc_pkg::ST_TEST;
          end else begin
            state_next = bmrsc_pkg::ST_DONE;
          end
        end
      end
      bmrsc_pkg::ST_RUN: begin
        if (cur == last_byte) begin
          state_next = bmrsc_pkg::ST_DRAIN;
        end
      end
      bmrsc_pkg::ST_DRAIN: state_next = bmrsc_pkg::ST_DONE;
      bmrsc_pkg::ST_TEST:  state_next = bmrsc_pkg::ST_DONE;
      bmrsc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bmrsc_pkg::ST_IDLE;
        end
      end
      default: state_next = bmrsc_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = set_op ? (rd_data | mask) : (rd_data & ~mask);
    mem_raddr = cur;
    case (state)
      bmrsc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'h00;
      end
      bmrsc_pkg::ST_IDLE: begin
        mem_raddr = AW'(start_byte_in);
      end
      default: begin
        mem_we = wr_pend;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmrsc_pkg::ST_CLEAR;
      clr_addr  <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == bmrsc_pkg::ST_RUN);
      if (state == bmrsc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == bmrsc_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr  <= cur;
    wr_first <= (cur == first_byte);
    wr_last  <= (cur == last_byte);
    case (state)
      bmrsc_pkg::ST_IDLE: begin
        cur        <= AW'(start_byte_in);
        first_byte <= AW'(start_byte_in);
        last_byte  <= AW'(end_byte_in);
        start_lo   <= start_bit[2:0];
        end_lo     <= end_bit[2:0];
        set_op     <= (req.func == bmrsc_pkg::FUNC_SET);
        res_bit    <= 1'b0;
        res_oor    <= (is_run && !run_zero && run_oor) || (is_test && test_oor);
      end
      bmrsc_pkg::ST_RUN: begin
        cur <= cur + 1'b1;
      end
      bmrsc_pkg::ST_TEST: begin
        res_bit <= rd_data[start_lo];
      end
      bmrsc_pkg::ST_DONE: begin
        if (out_free) begin
          out_bit <= res_bit;
          out_oor <= res_oor;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == bmrsc_pkg::ST_IDLE |-> !mem_we)
    else $error("store written while idle");

  a_run_writes_back: assert property (@(posedge clk) disable iff (rst)
    state == bmrsc_pkg::ST_RUN |=> mem_we && (mem_waddr == $past(cur)))
    else $error("read byte not written back");

  a_oor_no_bit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_of_range |-> !rsp.bit_value)
    else $error("out-of-range result carries a bit value");

  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    state == bmrsc_pkg::ST_CLEAR |-> !req.ready)
    else $error("request accepted during store clear");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_BYTES = bmrsc_pkg::STORE_BYTES_DEF;
  localparam int STORE_BITS = STORE_BYTES * 8;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] byte_base;
    logic [14:0] first_bit;
    logic [15:0] bit_count;
  } access_req_t;

  typedef struct packed {
    logic bit_value;
    logic out_of_range;
  } access_rsp_t;

  typedef struct packed {
    access_req_t stim;
    access_rsp_t rsp_val;
  } access_expect_t;

  typedef struct packed {
    access_req_t stim;
    logic        typed;
    access_rsp_t rsp_val;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic clk;
  logic rst;
  logic rsp_ready_drv = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_phase_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int burst_left = 0;

  logic [7:0] bitmap_model [STORE_BYTES];
  access_expect_t pending_rsp_q [$];
  dir_row_t dir_rows [$];
  access_expect_t head_exp;

  bmrsc_req_if req ();
  bmrsc_rsp_if rsp ();

  assign rsp.ready = rsp_ready_drv;

  bitmap_range_set_clear_core #(
    .STORE_BYTES(STORE_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic access_rsp_t predict_access(input access_req_t r);
    int start_bit;
    int last_bit;
    logic [7:0] mask;
    access_rsp_t res;
    res = '0;
    start_bit = int'(r.byte_base) * 8 + int'(r.first_bit);
    case (r.func)
      bmrsc_pkg::FUNC_SET, bmrsc_pkg::FUNC_CLR: begin
        if (r.bit_count != 16'd0) begin
          last_bit = start_bit + int'(r.bit_count) - 1;
          if ((last_bit >> 3) >= STORE_BYTES) begin
            res.out_of_range = 1'b1;
          end else begin
            for (int b = start_bit >> 3; b <= (last_bit >> 3); b++) begin
              mask = 8'hFF;
              if (b == (start_bit >> 3)) mask = mask & (8'hFF << (start_bit % 8));
              if (b == (last_bit >> 3)) mask = mask & (8'hFF >> (7 - (last_bit % 8)));
              if (r.func == bmrsc_pkg::FUNC_SET) bitmap_model[b] = bitmap_model[b] | mask;
              else bitmap_model[b] = bitmap_model[b] & ~mask;
            end
          end
        end
      end
      bmrsc_pkg::FUNC_TEST: begin
        if ((start_bit >> 3) >= STORE_BYTES) res.out_of_range = 1'b1;
        else res.bit_value = bitmap_model[start_bit >> 3][start_bit % 8];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic add_row(input logic [1:0] func, input int base, input int first,
                         input int count, input logic typed, input logic bitv,
                         input logic oor);
    dir_row_t row;
    row.stim.func = func;
    row.stim.byte_base = 12'(base);
    row.stim.first_bit = 15'(first);
    row.stim.bit_count = 16'(count);
    row.typed = typed;
    row.rsp_val.bit_value = bitv;
    row.rsp_val.out_of_range = oor;
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input access_req_t stim, input logic typed,
                              input access_rsp_t typed_rsp);
    access_expect_t entry;
    int gap;
    req.valid <= 1'b1;
    req.func <= stim.func;
    req.byte_base <= stim.byte_base;
    req.first_bit <= stim.first_bit;
    req.bit_count <= stim.bit_count;
    do @(posedge clk); while (req.ready !== 1'b1);
    entry.stim = stim;
    entry.rsp_val = predict_access(stim);
    if (typed) entry.rsp_val = typed_rsp;
    pending_rsp_q.push_back(entry);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // response sink back-pressure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_phase_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(50, 300);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     rsp_ready_drv <= 1'b1;
      STALL_RANDOM:   rsp_ready_drv <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: rsp_ready_drv <= ((cycle_count % 5) != 0);
      STALL_HEAVY:    rsp_ready_drv <= ((cycle_count % 16) == 0);
      default:        rsp_ready_drv <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_range_set_clear_core verification failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        flag_error($sformatf("unexpected transaction: bit_value=%0b out_of_range=%0b",
                             rsp.bit_value, rsp.out_of_range));
      end else begin
        head_exp = pending_rsp_q.pop_front();
        if (rsp.bit_value !== head_exp.rsp_val.bit_value ||
            rsp.out_of_range !== head_exp.rsp_val.out_of_range) begin
          flag_error($sformatf(
            {"mismatch func=%0d base=%0d first=%0d count=%0d: ",
             "exp bit=%0b oor=%0b, got bit=%0b oor=%0b"},
            head_exp.stim.func, head_exp.stim.byte_base, head_exp.stim.first_bit,
            head_exp.stim.bit_count, head_exp.rsp_val.bit_value,
            head_exp.rsp_val.out_of_range, rsp.bit_value, rsp.out_of_range));
        end
      end
    end
  end

  initial begin
    access_req_t item;
    access_rsp_t no_rsp;
    int start_bit;
    int hot_bit;
    int pick;
    int count;

    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FUNC_NONE;
    req.byte_base = '0;
    req.first_bit = '0;
    req.bit_count = '0;
    no_rsp = '0;
    hot_bit = 0;
    for (int b = 0; b < STORE_BYTES; b++) bitmap_model[b] = 8'h00;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_row(bmrsc_pkg::FUNC_TEST, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 4095, 7, 0, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 4095, 8, 0, 1'b1, 1'b0, 1'b1);
    add_row(bmrsc_pkg::FUNC_TEST, 0, 32767, 0, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_SET, 0, 0, 1, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 0, 0, 0, 1'b1, 1'b1, 1'b0);
    add_row(bmrsc_pkg::FUNC_SET, 4095, 32767, 0, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_SET, 0, 0, 32768, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 4095, 7, 0, 1'b1, 1'b1, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 0, 32767, 0, 1'b1, 1'b1, 1'b0);
    add_row(bmrsc_pkg::FUNC_CLR, 0, 3, 10, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 0, 5, 0, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 0, 2, 0, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 0, 13, 0, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_SET, 4095, 0, 9, 1'b1, 1'b0, 1'b1);
    add_row(bmrsc_pkg::FUNC_CLR, 4095, 32767, 65535, 1'b1, 1'b0, 1'b1);
    add_row(FUNC_NONE, 4095, 32767, 65535, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_NONE, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_CLR, 0, 0, 32768, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 2048, 0, 0, 1'b1, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_SET, 100, 5, 3, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 100, 6, 0, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_SET, 10, 7, 18, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_TEST, 12, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(bmrsc_pkg::FUNC_CLR, 4095, 32767, 0, 1'b1, 1'b0, 1'b0);

    foreach (dir_rows[i]) send_request(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].rsp_val);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) hot_bit = $urandom_range(0, STORE_BITS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // raw noise, mostly outside the store
        item.func = 2'($urandom);
        item.byte_base = 12'($urandom);
        item.first_bit = 15'($urandom);
        item.bit_count = 16'($urandom);
      end else begin
        if ($urandom_range(0, 4) == 0) start_bit = $urandom_range(0, STORE_BITS - 1);
        else start_bit = hot_bit + $urandom_range(0, 511);
        if (start_bit > STORE_BITS - 1) start_bit = STORE_BITS - 1;
        pick = $urandom_range(0, 99);
        if (pick < 35) item.func = bmrsc_pkg::FUNC_SET;
        else if (pick < 60) item.func = bmrsc_pkg::FUNC_CLR;
        else if (pick < 97) item.func = bmrsc_pkg::FUNC_TEST;
        else item.func = FUNC_NONE;
        item.byte_base = 12'($urandom_range(0, start_bit >> 3));
        item.first_bit = 15'(start_bit - int'(item.byte_base) * 8);
        pick = $urandom_range(0, 99);
        if (n % 50 == 25) count = $urandom_range(1, STORE_BITS - start_bit);
        else if (pick < 5) count = 0;
        else if (pick < 10) count = STORE_BITS - start_bit + $urandom_range(0, 100);
        else if (pick < 70) count = $urandom_range(1, 16);
        else count = $urandom_range(1, 256);
        item.bit_count = 16'(count);
      end
      send_request(item, 1'b0, no_rsp);
    end
    req.valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("bitmap_range_set_clear_core verification clean");
    end else begin
      $display("bitmap_range_set_clear_core verification failed");
    end
    $finish;
  end

endmodule
